/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Every macro samples on posedge clk; the checker module must declare clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is disabled while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mqd_pkg.sv */
// Package for the multi-server queue dispatcher: sizes, codes, reset values and structs.
// It depends on nothing; the remainder unit, the wait queue and the top level use it.
`default_nettype none

package mqd_pkg;

  localparam int NUM_SERVERS = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int SRV_IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int SRV_CW = $clog2(NUM_SERVERS + 1);
  localparam int Q_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_FW   = $clog2(QUEUE_DEPTH + 1);

  localparam int TAG_W   = 5;
  localparam int DRAW_W  = 8;
  localparam int SPAN_W  = 9;
  localparam int DRAW_CW = $clog2(DRAW_W);
  localparam int CFG_AW  = 5;

  localparam logic [TAG_W-1:0] TAG_LAST = 5'd25;

  // Register reset values
  localparam logic [3:0]  RST_ACTIVE_SERVERS = 4'd4;
  localparam logic [8:0]  RST_MAX_QUEUE_LEN  = 9'd16;
  localparam logic [7:0]  RST_MIN_SERVICE    = 8'd1;
  localparam logic [7:0]  RST_MAX_SERVICE    = 8'd8;
  localparam logic [31:0] RST_ARRIVAL_STOP   = 32'd60;

  typedef enum logic [2:0] {
    REG_ACTIVE_SERVERS   = 3'd0,
    REG_MAX_QUEUE_LENGTH = 3'd1,
    REG_MIN_SERVICE_TIME = 3'd2,
    REG_MAX_SERVICE_TIME = 3'd3,
    REG_ARRIVAL_STOP     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_ARRIVE,
    ST_SCAN,
    ST_DIV,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef enum logic {
    KIND_DISPATCH = 1'b0,
    KIND_STATUS   = 1'b1
  } kind_t;

  typedef struct packed {
    logic              start;
    logic [DRAW_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [DRAW_W-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [TAG_W-1:0] tag;
  } q_cmd_t;

  typedef struct packed {
    logic [Q_FW-1:0]  fill;
    logic [TAG_W-1:0] head_tag;
  } q_stat_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  server_index;
    logic [4:0]  customer_tag;
    logic [31:0] service_end_tick;
    logic [7:0]  busy_mask;
    logic [8:0]  queue_length;
    logic [3:0]  dropped_count;
    logic        simulation_done;
    logic        last;
  } out_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/mqd_if.sv */
// Valid/ready channel interfaces: tick items in, dispatch and status items out.
// Standalone; used by the top level and by whatever drives it.
`default_nettype none

interface mqd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  arrival_count;
  logic [63:0] random_bits;

  modport source (output valid, output arrival_count, output random_bits, input ready);
  modport sink   (input valid, input arrival_count, input random_bits, output ready);
endinterface

interface mqd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  server_index;
  logic [4:0]  customer_tag;
  logic [31:0] service_end_tick;
  logic [7:0]  busy_mask;
  logic [8:0]  queue_length;
  logic [3:0]  dropped_count;
  logic        simulation_done;
  logic        last;

  modport source (output valid, output kind, output server_index, output customer_tag,
                  output service_end_tick, output busy_mask, output queue_length,
                  output dropped_count, output simulation_done, output last,
                  input ready);
  modport sink   (input valid, input kind, input server_index, input customer_tag,
                  input service_end_tick, input busy_mask, input queue_length,
                  input dropped_count, input simulation_done, input last,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/mqd_rem_unit.sv */
// Shared iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on mqd_pkg.
`default_nettype none

module mqd_rem_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  mqd_pkg::rem_req_t req,
  output mqd_pkg::rem_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [mqd_pkg::DRAW_CW-1:0] cnt_r, cnt_nxt;
  logic [mqd_pkg::DRAW_W-1:0]  dvd_r, dvd_nxt;
  logic [mqd_pkg::SPAN_W-1:0]  dvs_r, dvs_nxt;
  logic [mqd_pkg::DRAW_W-1:0]  rem_r, rem_nxt;

  logic [mqd_pkg::SPAN_W-1:0]  trial;
  logic [mqd_pkg::SPAN_W-1:0]  trial_sub;

  // partial remainder stays below the divisor (at most 256), so 8 bits hold it
  assign trial     = {rem_r, dvd_r[mqd_pkg::DRAW_W-1]};
  assign trial_sub = (trial >= dvs_r) ? (trial - dvs_r) : trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = trial_sub[mqd_pkg::DRAW_W-1:0];
      dvd_nxt = {dvd_r[mqd_pkg::DRAW_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mqd_pkg::DRAW_CW'(mqd_pkg::DRAW_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

/* hw/rtl/mqd_wait_queue.sv */
// Wait queue of customer tags: circular buffer memory with head pointer and fill count.
// Depends on mqd_pkg. Read data is registered from the head entry every cycle.
`default_nettype none

module mqd_wait_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  mqd_pkg::q_cmd_t  cmd,
  output mqd_pkg::q_stat_t stat
);

  logic [mqd_pkg::Q_AW-1:0]  head_r, head_nxt;
  logic [mqd_pkg::Q_FW-1:0]  fill_r, fill_nxt;
  logic [mqd_pkg::TAG_W-1:0] rd_r;
  logic [mqd_pkg::TAG_W-1:0] mem [mqd_pkg::QUEUE_DEPTH];

  logic [mqd_pkg::Q_AW:0]    tail_sum;
  logic [mqd_pkg::Q_AW:0]    tail_wrap;
  logic [mqd_pkg::Q_AW-1:0]  tail;

  // head < depth and fill < depth on a push, so one subtract wraps the sum
  assign tail_sum  = (mqd_pkg::Q_AW + 1)'(head_r) + (mqd_pkg::Q_AW + 1)'(fill_r);
  assign tail_wrap = (tail_sum >= (mqd_pkg::Q_AW + 1)'(mqd_pkg::QUEUE_DEPTH))
                   ? tail_sum - (mqd_pkg::Q_AW + 1)'(mqd_pkg::QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[mqd_pkg::Q_AW-1:0];

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (cmd.push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (cmd.pop) begin
      fill_nxt = fill_r - 1'b1;
      head_nxt = (head_r == mqd_pkg::Q_AW'(mqd_pkg::QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= cmd.tag;
    end
    rd_r <= mem[head_r];
  end

  assign stat.fill     = fill_r;
  assign stat.head_tag = rd_r;

endmodule

`default_nettype wire

/* hw/rtl/multi_server_queue_dispatcher_core.sv */
// Multi-server queue dispatcher, top level: sequencer, server state, config registers.
// Depends on mqd_pkg, mqd_if, mqd_rem_unit and mqd_wait_queue.
//
// Usage:
//   in_ch carries one item per simulated clock tick: arrival_count customers
//   and a 64-bit random word whose byte i draws the service time of server i.
//   out_ch returns, per tick, one dispatch item for every customer handed to
//   an idle server (kind 0), then one status item (kind 1, last 1) that holds
//   drop count, queue length, busy mask and the done flag.
//   cfg_* is an APB-style port; register i sits at byte address 4*i, pready is
//   always high, writes belong in idle time between ticks.
// Timing:
//   in_ch.ready is high only while the sequencer waits for a tick. One tick
//   admits its arrivals (if arrivals are open), scans the servers and makes
//   its dispatches: arrivals enter the queue one per cycle, and each
//   dispatch waits on the shared remainder unit.
// Reset (rst_n low, synchronous): tick 0, queue empty, all servers idle,
//   tag counter 0, registers to defaults, no item pending on out_ch.
// Stalls: a single output register holds one item; while out_ch.ready stays
//   low the sequencer waits before loading the next one, nothing is lost.
`default_nettype none

module multi_server_queue_dispatcher_core (
  input  wire                          clk,
  input  wire                          rst_n,
  mqd_in_if.sink                       in_ch,
  mqd_out_if.source                    out_ch,
  input  wire                          cfg_psel,
  input  wire                          cfg_penable,
  input  wire                          cfg_pwrite,
  input  wire  [mqd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire  [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [3:0]  act_r;
  logic [8:0]  maxq_r;
  logic [7:0]  mins_r;
  logic [7:0]  maxs_r;
  logic [31:0] stop_r;

  logic              cfg_wr;
  mqd_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = mqd_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= mqd_pkg::RST_ACTIVE_SERVERS;
      maxq_r <= mqd_pkg::RST_MAX_QUEUE_LEN;
      mins_r <= mqd_pkg::RST_MIN_SERVICE;
      maxs_r <= mqd_pkg::RST_MAX_SERVICE;
      stop_r <= mqd_pkg::RST_ARRIVAL_STOP;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mqd_pkg::REG_ACTIVE_SERVERS:   act_r  <= cfg_pwdata[3:0];
        mqd_pkg::REG_MAX_QUEUE_LENGTH: maxq_r <= cfg_pwdata[8:0];
        mqd_pkg::REG_MIN_SERVICE_TIME: mins_r <= cfg_pwdata[7:0];
        mqd_pkg::REG_MAX_SERVICE_TIME: maxs_r <= cfg_pwdata[7:0];
        mqd_pkg::REG_ARRIVAL_STOP:     stop_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mqd_pkg::REG_ACTIVE_SERVERS:   cfg_prdata = 32'(act_r);
      mqd_pkg::REG_MAX_QUEUE_LENGTH: cfg_prdata = 32'(maxq_r);
      mqd_pkg::REG_MIN_SERVICE_TIME: cfg_prdata = 32'(mins_r);
      mqd_pkg::REG_MAX_SERVICE_TIME: cfg_prdata = 32'(maxs_r);
      mqd_pkg::REG_ARRIVAL_STOP:     cfg_prdata = stop_r;
      default:                       cfg_prdata = '0;
    endcase
  end

  // Derived limits: clamp to built sizes, collapse an inverted service range.
  logic [8:0] q_limit;
  logic [3:0] n_srv;
  logic [mqd_pkg::SPAN_W-1:0] span;

  assign q_limit = (maxq_r > 9'(mqd_pkg::QUEUE_DEPTH)) ? 9'(mqd_pkg::QUEUE_DEPTH) : maxq_r;
  assign n_srv   = (act_r > 4'(mqd_pkg::NUM_SERVERS)) ? 4'(mqd_pkg::NUM_SERVERS) : act_r;
  assign span    = (maxs_r >= mins_r) ? ({1'b0, maxs_r} - {1'b0, mins_r} + 9'd1) : 9'd1;

  // ---------------------------------------------------------------- state
  mqd_pkg::state_t state_r, state_nxt;

  logic [31:0]                     tick_r, tick_nxt;
  logic [3:0]                      arr_r, arr_nxt;
  logic [63:0]                     rnd_r, rnd_nxt;
  logic                            open_r, open_nxt;
  logic [3:0]                      arr_idx_r, arr_idx_nxt;
  logic [3:0]                      drop_r, drop_nxt;
  logic [mqd_pkg::SRV_CW-1:0]      srv_r, srv_nxt;
  logic [mqd_pkg::NUM_SERVERS-1:0] busy_r, busy_nxt;
  logic [mqd_pkg::TAG_W-1:0]       tag_cnt_r, tag_cnt_nxt;
  logic [31:0]                     end_r [mqd_pkg::NUM_SERVERS];
  mqd_pkg::out_rec_t               out_r, out_nxt;
  logic                            out_vld_r, out_vld_nxt;

  logic                            end_we;
  logic [31:0]                     end_val;
  logic [mqd_pkg::SRV_IW-1:0]      srv_idx;
  logic [mqd_pkg::NUM_SERVERS-1:0] busy_set;
  logic                            slot_free;
  logic                            scan_done;
  logic                            can_disp;
  logic                            arr_more;

  mqd_pkg::rem_req_t rem_req;
  mqd_pkg::rem_rsp_t rem_rsp;
  mqd_pkg::q_cmd_t   q_cmd;
  mqd_pkg::q_stat_t  q_stat;

  mqd_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  mqd_wait_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .stat  (q_stat)
  );

  assign srv_idx   = srv_r[mqd_pkg::SRV_IW-1:0];
  assign busy_set  = busy_r | (mqd_pkg::NUM_SERVERS'(1) << srv_idx);
  assign slot_free = !out_vld_r || out_ch.ready;
  assign scan_done = (4'(srv_r) >= n_srv);
  assign can_disp  = !busy_r[srv_idx] && (q_stat.fill != '0);
  assign arr_more  = open_r && (arr_idx_r != arr_r);
  // min plus remainder is narrow; one 32-bit add with the tick
  assign end_val   = tick_r + 32'(9'(mins_r) + 9'(rem_rsp.rem));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mqd_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = mqd_pkg::ST_FREE;
      mqd_pkg::ST_FREE:   state_nxt = mqd_pkg::ST_ARRIVE;
      mqd_pkg::ST_ARRIVE: if (!arr_more) state_nxt = mqd_pkg::ST_SCAN;
      mqd_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = mqd_pkg::ST_STATUS;
        else if (can_disp) state_nxt = mqd_pkg::ST_DIV;
      end
      mqd_pkg::ST_DIV:    if (rem_rsp.done) state_nxt = mqd_pkg::ST_EMIT;
      mqd_pkg::ST_EMIT:   if (slot_free) state_nxt = mqd_pkg::ST_SCAN;
      mqd_pkg::ST_STATUS: if (slot_free) state_nxt = mqd_pkg::ST_IDLE;
      default:            state_nxt = mqd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    tick_nxt    = tick_r;
    arr_nxt     = arr_r;
    rnd_nxt     = rnd_r;
    open_nxt    = open_r;
    arr_idx_nxt = arr_idx_r;
    drop_nxt    = drop_r;
    srv_nxt     = srv_r;
    busy_nxt    = busy_r;
    tag_cnt_nxt = tag_cnt_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    end_we      = 1'b0;

    rem_req.start    = 1'b0;
    rem_req.dividend = rnd_r[8*srv_idx +: 8];
    rem_req.divisor  = span;

    q_cmd.push = 1'b0;
    q_cmd.pop  = 1'b0;
    q_cmd.tag  = tag_cnt_r;

    unique case (state_r)
      mqd_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          arr_nxt = in_ch.arrival_count;
          rnd_nxt = in_ch.random_bits;
        end
      end
      mqd_pkg::ST_FREE: begin
        // release servers ending now, all in parallel
        for (int i = 0; i < mqd_pkg::NUM_SERVERS; i++) begin
          if (busy_r[i] && (end_r[i] == tick_r)) busy_nxt[i] = 1'b0;
        end
        open_nxt    = (tick_r < stop_r);
        arr_idx_nxt = '0;
        drop_nxt    = '0;
        srv_nxt     = '0;
      end
      mqd_pkg::ST_ARRIVE: begin
        if (arr_more) begin
          arr_idx_nxt = arr_idx_r + 1'b1;
          if (9'(q_stat.fill) < q_limit) begin
            q_cmd.push  = 1'b1;
            tag_cnt_nxt = (tag_cnt_r == mqd_pkg::TAG_LAST) ? '0 : tag_cnt_r + 1'b1;
          end else begin
            drop_nxt = drop_r + 1'b1;
          end
        end
      end
      mqd_pkg::ST_SCAN: begin
        if (!scan_done) begin
          if (can_disp) rem_req.start = 1'b1;
          else          srv_nxt       = srv_r + 1'b1;
        end
      end
      mqd_pkg::ST_DIV: ;
      mqd_pkg::ST_EMIT: begin
        if (slot_free) begin
          end_we    = 1'b1;
          busy_nxt  = busy_set;
          q_cmd.pop = 1'b1;
          srv_nxt   = srv_r + 1'b1;
          out_vld_nxt             = 1'b1;
          out_nxt.kind            = mqd_pkg::KIND_DISPATCH;
          out_nxt.server_index    = 3'(srv_idx);
          out_nxt.customer_tag    = q_stat.head_tag;
          out_nxt.service_end_tick = end_val;
          out_nxt.busy_mask       = 8'(busy_set);
          out_nxt.queue_length    = 9'(q_stat.fill - 1'b1);
          out_nxt.dropped_count   = drop_r;
          out_nxt.simulation_done = 1'b0;
          out_nxt.last            = 1'b0;
        end
      end
      mqd_pkg::ST_STATUS: begin
        if (slot_free) begin
          tick_nxt                = tick_r + 32'd1;
          out_vld_nxt             = 1'b1;
          out_nxt.kind            = mqd_pkg::KIND_STATUS;
          out_nxt.server_index    = '0;
          out_nxt.customer_tag    = '0;
          out_nxt.service_end_tick = '0;
          out_nxt.busy_mask       = 8'(busy_r);
          out_nxt.queue_length    = 9'(q_stat.fill);
          out_nxt.dropped_count   = drop_r;
          out_nxt.simulation_done = (q_stat.fill == '0) && (tick_r > stop_r) && (busy_r == '0);
          out_nxt.last            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mqd_pkg::ST_IDLE;
      tick_r    <= '0;
      open_r    <= 1'b0;
      arr_idx_r <= '0;
      drop_r    <= '0;
      srv_r     <= '0;
      busy_r    <= '0;
      tag_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tick_r    <= tick_nxt;
      open_r    <= open_nxt;
      arr_idx_r <= arr_idx_nxt;
      drop_r    <= drop_nxt;
      srv_r     <= srv_nxt;
      busy_r    <= busy_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    arr_r <= arr_nxt;
    rnd_r <= rnd_nxt;
    out_r <= out_nxt;
    if (end_we) end_r[srv_idx] <= end_val;
  end

  // ---------------------------------------------------------------- ports
  assign in_ch.ready             = (state_r == mqd_pkg::ST_IDLE);
  assign out_ch.valid            = out_vld_r;
  assign out_ch.kind             = out_r.kind;
  assign out_ch.server_index     = out_r.server_index;
  assign out_ch.customer_tag     = out_r.customer_tag;
  assign out_ch.service_end_tick = out_r.service_end_tick;
  assign out_ch.busy_mask        = out_r.busy_mask;
  assign out_ch.queue_length     = out_r.queue_length;
  assign out_ch.dropped_count    = out_r.dropped_count;
  assign out_ch.simulation_done  = out_r.simulation_done;
  assign out_ch.last             = out_r.last;

endmodule

`default_nettype wire

/* hw/rtl/mqd_checker.sv */
// Port-level checker for the dispatcher top level, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mqd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_kind,
  input wire        out_last,
  input wire [31:0] out_service_end_tick,
  input wire [7:0]  out_busy_mask
);

  // stalled result holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_service_end_tick) && $stable(out_busy_mask), "stalled output item changed")

  // a tick in progress blocks the next one
  `ASSERT_CLK(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input ready right after accept")

  // a dispatch item always comes before its tick's status, so the tick is open
  `ASSERT_CLK(a_dispatch_mid_tick, out_valid && !out_last |-> !in_ready, "ready while dispatch pending")

  `ASSERT_CLK_NR(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind multi_server_queue_dispatcher_core mqd_checker u_mqd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_kind             (out_ch.kind),
  .out_last             (out_ch.last),
  .out_service_end_tick (out_ch.service_end_tick),
  .out_busy_mask        (out_ch.busy_mask)
);

`default_nettype wire

/* bench/multi_server_queue_dispatcher_core_tb.sv */
// Self-checking bench for multi_server_queue_dispatcher_core: directed tick table, then random ticks.
// Depends on mqd_pkg, mqd_if and the core RTL; an in-bench tick predictor supplies expected items.
`default_nettype none

module multi_server_queue_dispatcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mqd_pkg::*;

  // Hard stop for a hung run; normal runs end well before this.
  localparam int unsigned RUN_LIMIT_NS = 10_000_000;
  // Cycles to watch for stray items after everything due has arrived.
  localparam int TAIL_CYCLES = 200;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_TICKS = 50;
  localparam int MAX_PRINTED = 40;

  // ---------------------------------------------------------------------------
  // Clock, reset, bench-side drivers
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench-owned copies of every DUT input; known from time zero.
  logic              tick_valid = 1'b0;
  logic [3:0]        tick_arrivals = '0;
  logic [63:0]       tick_random = '0;
  logic              sink_ready = 1'b0;
  logic              cfg_sel = 1'b0;
  logic              cfg_en = 1'b0;
  logic              cfg_wr = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [31:0]       cfg_wdata = '0;
  logic [31:0]       cfg_rdata;
  logic              cfg_rdy;

  mqd_in_if  in_bus ();
  mqd_out_if out_bus ();

  assign in_bus.valid         = tick_valid;
  assign in_bus.arrival_count = tick_arrivals;
  assign in_bus.random_bits   = tick_random;
  assign out_bus.ready        = sink_ready;

  multi_server_queue_dispatcher_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_sel),
    .cfg_penable (cfg_en),
    .cfg_pwrite  (cfg_wr),
    .cfg_paddr   (cfg_addr),
    .cfg_pwdata  (cfg_wdata),
    .cfg_prdata  (cfg_rdata),
    .cfg_pready  (cfg_rdy)
  );

  // Idle percentages per side, changed per phase by the stimulus process.
  int src_idle  = 20;
  int sink_idle = 83;

  // Receiver backpressure: random ready, redrawn every cycle.
  always @(posedge clk) begin
    sink_ready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // ---------------------------------------------------------------------------
  // Tick predictor: shadow registers and shadow dispatcher state
  // ---------------------------------------------------------------------------
  logic [3:0]  cur_servers = RST_ACTIVE_SERVERS;
  logic [8:0]  cur_qlimit  = RST_MAX_QUEUE_LEN;
  logic [7:0]  cur_min     = RST_MIN_SERVICE;
  logic [7:0]  cur_max     = RST_MAX_SERVICE;
  logic [31:0] cur_stop    = RST_ARRIVAL_STOP;

  logic [31:0]            sim_tick = '0;
  logic [NUM_SERVERS-1:0] srv_busy = '0;
  logic [31:0]            srv_end [NUM_SERVERS];
  logic [TAG_W-1:0]       wq_tag [QUEUE_DEPTH];
  int unsigned            wq_head = 0;
  int unsigned            wq_fill = 0;
  logic [TAG_W-1:0]       next_tag = '0;

  out_rec_t tick_recs[$];     // items one tick produces, in order
  out_rec_t due_records[$];   // items the DUT still owes us
  int       err_count = 0;
  int       seen_items = 0;

  // One tick: free finished servers, queue arrivals, fill idle servers, close with status.
  task automatic serve_tick(input logic [3:0] arrivals, input logic [63:0] rnd);
    logic [31:0]      now;
    logic [3:0]       dropped;
    int unsigned      limit;
    int unsigned      n_srv;
    int unsigned      span;
    logic [7:0]       draw;
    logic [31:0]      done_at;
    logic [TAG_W-1:0] tag;
    out_rec_t         rec;
    now = sim_tick;
    dropped = '0;
    tick_recs.delete();

    // Free before anything else; a zero-length service never matches here on its own tick.
    for (int i = 0; i < NUM_SERVERS; i++)
      if (srv_busy[i] && srv_end[i] == now) srv_busy[i] = 1'b0;

    // Late arrivals vanish without being counted as drops.
    if (now < cur_stop) begin
      limit = (cur_qlimit > QUEUE_DEPTH) ? QUEUE_DEPTH : cur_qlimit;
      for (int a = 0; a < arrivals; a++) begin
        if (wq_fill < limit) begin
          wq_tag[(wq_head + wq_fill) % QUEUE_DEPTH] = next_tag;
          next_tag = (next_tag == TAG_LAST) ? '0 : next_tag + 1'b1;
          wq_fill++;
        end else begin
          dropped++;
        end
      end
    end

    // Inverted range collapses to a fixed min-length service.
    n_srv = (cur_servers > NUM_SERVERS) ? NUM_SERVERS : cur_servers;
    span  = (cur_max >= cur_min) ? int'(cur_max) - int'(cur_min) + 1 : 1;
    for (int i = 0; i < n_srv; i++) begin
      if (!srv_busy[i] && wq_fill > 0) begin
        tag     = wq_tag[wq_head];
        draw    = rnd[8*i +: 8];
        done_at = now + 32'(cur_min) + 32'(int'(draw) % span);
        wq_head = (wq_head + 1) % QUEUE_DEPTH;
        wq_fill--;
        srv_busy[i] = 1'b1;
        srv_end[i]  = done_at;
        rec = '0;
        rec.kind             = KIND_DISPATCH;
        rec.server_index     = 3'(i);
        rec.customer_tag     = tag;
        rec.service_end_tick = done_at;
        rec.busy_mask        = 8'(srv_busy);
        rec.queue_length     = 9'(wq_fill);
        rec.dropped_count    = dropped;
        tick_recs.push_back(rec);
      end
    end

    // Status closes every tick; servers beyond active_servers still count.
    rec = '0;
    rec.kind            = KIND_STATUS;
    rec.busy_mask       = 8'(srv_busy);
    rec.queue_length    = 9'(wq_fill);
    rec.dropped_count   = dropped;
    rec.simulation_done = (wq_fill == 0 && now > cur_stop && srv_busy == '0);
    rec.last            = 1'b1;
    tick_recs.push_back(rec);

    sim_tick = now + 32'd1;
  endtask

  // ---------------------------------------------------------------------------
  // Output checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("MISMATCH %0d at %0t, output item %0d: %s got 'h%0h want 'h%0h",
               err_count, $realtime, seen_items, what, got, want);
  endtask

  // Every accepted output item is compared against the oldest due item.
  always @(posedge clk) begin
    out_rec_t want;
    if (rst_n && out_bus.valid && sink_ready) begin
      if (due_records.size() == 0) begin
        flag_mismatch("item with nothing due, kind", out_bus.kind, '0);
      end else begin
        want = due_records.pop_front();
        if (out_bus.kind !== want.kind)
          flag_mismatch("kind", out_bus.kind, want.kind);
        if (out_bus.server_index !== want.server_index)
          flag_mismatch("server_index", out_bus.server_index, want.server_index);
        if (out_bus.customer_tag !== want.customer_tag)
          flag_mismatch("customer_tag", out_bus.customer_tag, want.customer_tag);
        if (out_bus.service_end_tick !== want.service_end_tick)
          flag_mismatch("service_end_tick", out_bus.service_end_tick,
                        want.service_end_tick);
        if (out_bus.busy_mask !== want.busy_mask)
          flag_mismatch("busy_mask", out_bus.busy_mask, want.busy_mask);
        if (out_bus.queue_length !== want.queue_length)
          flag_mismatch("queue_length", out_bus.queue_length, want.queue_length);
        if (out_bus.dropped_count !== want.dropped_count)
          flag_mismatch("dropped_count", out_bus.dropped_count, want.dropped_count);
        if (out_bus.simulation_done !== want.simulation_done)
          flag_mismatch("simulation_done", out_bus.simulation_done,
                        want.simulation_done);
        if (out_bus.last !== want.last)
          flag_mismatch("last", out_bus.last, want.last);
      end
      seen_items++;
    end
  end

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Offer one tick item; returns in the time step of the accepting edge.
  // Valid is only dropped during gaps, so back-to-back items keep it high.
  task automatic send_tick(input logic [3:0] arrivals, input logic [63:0] rnd);
    while ($urandom_range(0, 99) < src_idle) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid    <= 1'b1;
    tick_arrivals <= arrivals;
    tick_random   <= rnd;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Hold off input until every due item is back and the sequencer waits for a tick.
  task automatic quiesce();
    tick_valid <= 1'b0;
    while (due_records.size() != 0 || !in_bus.ready) @(posedge clk);
  endtask

  // APB write: setup, access, commit on pready; psel then drops before return, keeping psel edges apart.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_sel   <= 1'b1;
    cfg_en    <= 1'b0;
    cfg_wr    <= 1'b1;
    cfg_addr  <= CFG_AW'(idx) << 2;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_en <= 1'b1;
    @(posedge clk);
    while (!cfg_rdy) @(posedge clk);
    case (idx)
      REG_ACTIVE_SERVERS:   cur_servers = val[3:0];
      REG_MAX_QUEUE_LENGTH: cur_qlimit  = val[8:0];
      REG_MIN_SERVICE_TIME: cur_min     = val[7:0];
      REG_MAX_SERVICE_TIME: cur_max     = val[7:0];
      REG_ARRIVAL_STOP:     cur_stop    = val;
      default: ;
    endcase
    cfg_sel <= 1'b0;
    cfg_en  <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_write;
    reg_idx_t    reg_sel;
    logic [31:0] wdata;
    logic [3:0]  arrivals;
    logic [63:0] rnd;
    bit          typed;      // status item typed in by hand, the tick yields nothing else
    out_rec_t    status;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic plan_row_t write_row(input reg_idx_t idx, input logic [31:0] val);
    plan_row_t r;
    r = '{default: '0, reg_sel: REG_ACTIVE_SERVERS, status: '0};
    r.is_write = 1'b1;
    r.reg_sel  = idx;
    r.wdata    = val;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic [3:0] arrivals, input logic [63:0] rnd);
    plan_row_t r;
    r = '{default: '0, reg_sel: REG_ACTIVE_SERVERS, status: '0};
    r.arrivals = arrivals;
    r.rnd      = rnd;
    return r;
  endfunction

  function automatic plan_row_t status_row(input logic [3:0] arrivals, input logic [63:0] rnd,
                                           input logic [7:0] busy, input logic [8:0] qlen,
                                           input logic [3:0] dropped);
    plan_row_t r;
    r = tick_row(arrivals, rnd);
    r.typed                = 1'b1;
    r.status               = '0;
    r.status.kind          = KIND_STATUS;
    r.status.busy_mask     = busy;
    r.status.queue_length  = qlen;
    r.status.dropped_count = dropped;
    r.status.last          = 1'b1;
    return r;
  endfunction

  function automatic logic [3:0] pick_arrivals();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 4'd0;
    if (roll < 8) return 4'($urandom_range(1, 3));
    if (roll < 9) return 4'($urandom_range(4, 15));
    return 4'd15;
  endfunction

  // Accept one tick and queue what it owes; typed rows replace the predicted status.
  task automatic run_tick(input logic [3:0] arrivals, input logic [63:0] rnd,
                          input bit typed, input out_rec_t status);
    send_tick(arrivals, rnd);
    serve_tick(arrivals, rnd);
    if (typed) due_records.push_back(status);
    else foreach (tick_recs[i]) due_records.push_back(tick_recs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          n_act;
    logic [31:0] v_act, v_qlim, v_min, v_max, v_stop;
    logic [63:0] rnd;

    // Right after reset: nothing queued, nothing busy, not done.
    plan.push_back(status_row(4'd0, 64'd0, 8'h00, 9'd0, 4'd0));
    // No servers: queue fills, then overflows.
    plan.push_back(write_row(REG_ACTIVE_SERVERS, 32'd0));
    plan.push_back(status_row(4'd15, 64'hA5A5_5A5A_C3C3_3C3C, 8'h00, 9'd15, 4'd0));
    plan.push_back(status_row(4'd15, 64'h0123_4567_89AB_CDEF, 8'h00, 9'd16, 4'd14));
    // Zero queue limit: every arrival is dropped.
    plan.push_back(write_row(REG_MAX_QUEUE_LENGTH, 32'd0));
    plan.push_back(status_row(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 9'd16, 4'd15));
    // Arrivals closed: ignored, not counted as dropped.
    plan.push_back(write_row(REG_ARRIVAL_STOP, 32'd0));
    plan.push_back(status_row(4'd15, 64'd0, 8'h00, 9'd16, 4'd0));
    plan.push_back(write_row(REG_ARRIVAL_STOP, 32'hFFFF_FFFF));
    // Oversized limit and server count clamp; inverted service range.
    plan.push_back(write_row(REG_MAX_QUEUE_LENGTH, 32'h0000_01FF));
    plan.push_back(write_row(REG_ACTIVE_SERVERS, 32'hFFFF_FFFF));
    plan.push_back(write_row(REG_MIN_SERVICE_TIME, 32'd5));
    plan.push_back(write_row(REG_MAX_SERVICE_TIME, 32'd2));
    plan.push_back(tick_row(4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    // All four busy until tick 10: four arrivals fit, eleven dropped.
    plan.push_back(status_row(4'd15, 64'h1357_9BDF_2468_ACE0, 8'h0F, 9'd16, 4'd11));
    // Longest fixed service, one server in use.
    plan.push_back(write_row(REG_ACTIVE_SERVERS, 32'd1));
    plan.push_back(write_row(REG_MIN_SERVICE_TIME, 32'd255));
    plan.push_back(write_row(REG_MAX_SERVICE_TIME, 32'd255));
    plan.push_back(tick_row(4'd0, 64'hDEAD_BEEF_0BAD_F00D));
    plan.push_back(tick_row(4'd3, 64'h0000_0000_0000_0001));
    plan.push_back(tick_row(4'd1, 64'h8000_0000_0000_0000));
    plan.push_back(tick_row(4'd2, 64'h7F7F_7F7F_7F7F_7F7F));
    // Range 1 to 255; other servers pick up the backlog.
    plan.push_back(write_row(REG_ACTIVE_SERVERS, 32'd4));
    plan.push_back(write_row(REG_MIN_SERVICE_TIME, 32'd1));
    plan.push_back(write_row(REG_MAX_SERVICE_TIME, 32'd255));
    plan.push_back(tick_row(4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(tick_row(4'd5, 64'd0));
    // Inverted range with max at zero.
    plan.push_back(write_row(REG_MIN_SERVICE_TIME, 32'd3));
    plan.push_back(write_row(REG_MAX_SERVICE_TIME, 32'd0));
    plan.push_back(tick_row(4'd7, 64'h55AA_55AA_55AA_55AA));
    plan.push_back(tick_row(4'd0, 64'hAA55_AA55_AA55_AA55));
    plan.push_back(tick_row(4'd15, 64'h0F0F_F0F0_0F0F_F0F0));
    // Fewer servers while upper ones are still busy.
    plan.push_back(write_row(REG_ACTIVE_SERVERS, 32'd2));
    plan.push_back(tick_row(4'd15, 64'hF0F0_0F0F_F0F0_0F0F));
    plan.push_back(tick_row(4'd4, 64'h1111_2222_3333_4444));
    plan.push_back(tick_row(4'd8, 64'h9999_AAAA_BBBB_CCCC));

    tick_arrivals <= '0;
    tick_random   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sender idles lightly, receiver heavily.
    src_idle  = 20;
    sink_idle = 83;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        quiesce();
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        run_tick(plan[i].arrivals, plan[i].rnd, plan[i].typed, plan[i].status);
      end
    end

    // Random part: a fresh register setting per phase.
    for (int p = 0; p < RAND_PHASES; p++) begin
      quiesce();
      n_act  = 4;
      v_qlim = 32'd16;
      v_min  = 32'd1;
      v_max  = 32'd8;
      v_stop = 32'hFFFF_FFFF;
      case (p)
        1: begin
          n_act = 3; v_qlim = 32'd6; v_min = 32'd2; v_max = 32'd12;
        end
        3: begin
          n_act = 8; v_qlim = 32'd256; v_min = 32'd1; v_max = 32'd3;
          v_stop = sim_tick + 32'd20;
        end
        5: begin
          v_max = 32'd4; v_stop = sim_tick + 32'd10;
        end
        6: begin
          // Arrivals closed from tick 0: backlog drains, done rises and stays.
          n_act = 2; v_qlim = 32'd3; v_max = 32'd5; v_stop = 32'd0;
        end
        7: begin
          // Zero-length services park servers for good; run it last.
          v_min = 32'd0; v_max = 32'd2;
        end
        2, 4: begin
          n_act  = $urandom_range(0, 15);
          v_qlim = $urandom_range(0, 511);
          v_min  = $urandom_range(1, 6);
          v_max  = $urandom_range(0, 10);
          v_stop = sim_tick + 32'($urandom_range(5, 40));
        end
        default: ;
      endcase
      v_act = 32'(n_act);
      write_reg(REG_ACTIVE_SERVERS, v_act);
      write_reg(REG_MAX_QUEUE_LENGTH, v_qlim);
      write_reg(REG_MIN_SERVICE_TIME, v_min);
      write_reg(REG_MAX_SERVICE_TIME, v_max);
      write_reg(REG_ARRIVAL_STOP, v_stop);

      // Idle mix: light sender / heavy receiver, then swapped, then none.
      if (p < 3) begin
        src_idle = 20; sink_idle = 83;
      end else if (p < 6) begin
        src_idle = 83; sink_idle = 20;
      end else begin
        src_idle = 0; sink_idle = 0;
      end

      for (int k = 0; k < PHASE_TICKS; k++) begin
        // Mid-phase hold-off: let the DUT drain completely, then resume.
        if (p == 1 && k == PHASE_TICKS / 2) quiesce();
        rnd = {$urandom, $urandom};
        run_tick(pick_arrivals(), rnd, 1'b0, '0);
      end
    end

    // Drain, then watch a while for anything extra.
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && due_records.size() == 0) begin
      $display("** multi_server_queue_dispatcher_core: PASSED **");
    end else begin
      $display("** multi_server_queue_dispatcher_core: FAILED **");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("** multi_server_queue_dispatcher_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
